@@ design/crc16_frame_receive_checker_assert.svh @@
// Assertion macros for the CRC-16 frame receive checker.
// Expects clk and rst_n in the scope of the including module.
`ifndef CRC16_FRAME_RECEIVE_CHECKER_ASSERT_SVH
`define CRC16_FRAME_RECEIVE_CHECKER_ASSERT_SVH

// property must hold at every clock edge outside reset
`define CRC16FRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// sequence expression must never be true
`define CRC16FRC_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ design/crc16frc_pkg.sv @@
// Shared constants, types and CRC-16 (poly 0x1021) nibble functions
// for the frame receive checker. No dependencies.
`default_nettype none

package crc16frc_pkg;

    typedef logic [1:0] status_t;

    localparam status_t ST_CONTINUE = 2'd0;
    localparam status_t ST_GOOD     = 2'd1;
    localparam status_t ST_CRC_ERR  = 2'd2;
    localparam status_t ST_FULL     = 2'd3;

    localparam int HEADER_BYTES = 16;
    localparam int CRC_BYTES    = 2;
    localparam int FRAME_MIN    = HEADER_BYTES + CRC_BYTES;

    localparam logic [15:0] LEN_LO_POS      = 16'd14;
    localparam logic [15:0] LEN_HI_POS      = 16'd15;
    localparam logic [15:0] MAX_LENGTH_RST  = 16'd1024;

    function automatic logic [15:0] nib_table(input logic [3:0] idx);
        logic [15:0] v;
        unique case (idx)
            4'h0: v = 16'h0000;
            4'h1: v = 16'h1021;
            4'h2: v = 16'h2042;
            4'h3: v = 16'h3063;
            4'h4: v = 16'h4084;
            4'h5: v = 16'h50a5;
            4'h6: v = 16'h60c6;
            4'h7: v = 16'h70e7;
            4'h8: v = 16'h8108;
            4'h9: v = 16'h9129;
            4'ha: v = 16'ha14a;
            4'hb: v = 16'hb16b;
            4'hc: v = 16'hc18c;
            4'hd: v = 16'hd1ad;
            4'he: v = 16'he1ce;
            4'hf: v = 16'hf1ef;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] crc_nibble(input logic [15:0] acc, input logic [3:0] nib);
        return {acc[11:0], 4'h0} ^ nib_table(acc[15:12] ^ nib);
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
        return crc_nibble(crc_nibble(acc, b[7:4]), b[3:0]);
    endfunction

endpackage

`default_nettype wire

@@ design/crc16_frame_receive_checker.sv @@
// Top level of the CRC-16 frame receive checker: input register, per-byte
// frame/CRC update, output register. Uses crc16frc_pkg and the assert header.
//
// Usage:
//   Input channel (in_valid, data_byte, in_stall): one received byte per beat.
//   Output channel (out_valid, status, frame_length, out_stall): one result
//   beat per input beat, in order. status 0 continue, 1 frame good (with
//   frame_length = total bytes), 2 CRC mismatch, 3 buffer full.
//   Config channel (cfg_valid, max_length, cfg_ready): cfg_ready is always
//   high; write max_length only while no bytes are in flight.
// Path: a byte waits in the input register, its result in the output register.
// Throughput: one byte per cycle unless the output stalls; the byte count
//   update and the two-nibble CRC step are combinational on the frame state.
// Reset: max_length returns to 1024, frame state and both stages clear.
// Stall: a stalled output beat holds; the input register keeps one more byte,
//   and in_stall rises once it is also full.
`default_nettype none

module crc16_frame_receive_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [15:0]      frame_length,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] max_length
);

    `include "crc16_frame_receive_checker_assert.svh"

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        out_valid_reg;
    crc16frc_pkg::status_t status_reg, status_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] max_length_reg;

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] payload_length_reg, payload_length_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [7:0]  crc_low_byte_reg, crc_low_byte_next;

    logic        out_load;
    logic        s1_fire;
    logic        in_fire;
    logic [16:0] pos_ext;
    logic [16:0] crc_end;
    logic [16:0] cnt;
    logic [15:0] crc_upd;
    logic [15:0] crc_got;

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign frame_length = frame_length_reg;

    assign out_load = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_load;
    assign in_stall = s1_valid_reg && !out_load;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    assign pos_ext = {1'b0, byte_count_reg};
    assign crc_end = {1'b0, payload_length_reg} + 17'(crc16frc_pkg::HEADER_BYTES);
    assign cnt     = pos_ext + 17'd1;
    assign crc_upd = crc16frc_pkg::crc_byte(running_crc_reg, s1_byte_reg);
    assign crc_got = {s1_byte_reg, crc_low_byte_reg};

    always_comb
    begin
        status_next         = crc16frc_pkg::ST_CONTINUE;
        frame_length_next   = 16'd0;
        byte_count_next     = byte_count_reg;
        payload_length_next = payload_length_reg;
        running_crc_next    = running_crc_reg;
        crc_low_byte_next   = crc_low_byte_reg;

        if (pos_ext < 17'(crc16frc_pkg::HEADER_BYTES))
        begin
            running_crc_next = crc_upd;
            if (byte_count_reg == crc16frc_pkg::LEN_LO_POS)
                payload_length_next = {payload_length_reg[15:8], s1_byte_reg};
            else if (byte_count_reg == crc16frc_pkg::LEN_HI_POS)
                payload_length_next = {s1_byte_reg, payload_length_reg[7:0]};
        end
        else if (pos_ext < crc_end)
        begin
            running_crc_next = crc_upd;
        end
        else if (pos_ext == crc_end)
        begin
            crc_low_byte_next = s1_byte_reg;
        end
        else if (crc_got == running_crc_reg)
        begin
            status_next       = crc16frc_pkg::ST_GOOD;
            frame_length_next = cnt[15:0];
        end
        else
        begin
            status_next = crc16frc_pkg::ST_CRC_ERR;
        end

        if (status_next == crc16frc_pkg::ST_CONTINUE)
        begin
            if (cnt >= {1'b0, max_length_reg})
                status_next = crc16frc_pkg::ST_FULL;
            else
                byte_count_next = cnt[15:0];
        end

        if (status_next != crc16frc_pkg::ST_CONTINUE)
        begin
            byte_count_next     = 16'd0;
            payload_length_next = 16'd0;
            running_crc_next    = 16'd0;
            crc_low_byte_next   = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            max_length_reg     <= crc16frc_pkg::MAX_LENGTH_RST;
            byte_count_reg     <= 16'd0;
            payload_length_reg <= 16'd0;
            running_crc_reg    <= 16'd0;
            crc_low_byte_reg   <= 8'd0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (out_load)
                out_valid_reg <= s1_valid_reg;
            if (cfg_valid && cfg_ready)
                max_length_reg <= max_length;
            if (s1_fire)
            begin
                byte_count_reg     <= byte_count_next;
                payload_length_reg <= payload_length_next;
                running_crc_reg    <= running_crc_next;
                crc_low_byte_reg   <= crc_low_byte_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_byte_reg <= data_byte;
        if (s1_fire)
        begin
            status_reg       <= status_next;
            frame_length_reg <= frame_length_next;
        end
    end

    // frame state restarts after every final status
    `CRC16FRC_ASSERT(a_clear_after_final,
        (s1_fire && status_next != crc16frc_pkg::ST_CONTINUE) |=> byte_count_reg == 16'd0,
        "frame state not cleared after final status")
    `CRC16FRC_ASSERT(a_len_only_good,
        (out_valid_reg && status_reg != crc16frc_pkg::ST_GOOD) |-> frame_length_reg == 16'd0,
        "frame_length nonzero on non-good status")
    `CRC16FRC_ASSERT(a_good_min_len,
        (out_valid_reg && status_reg == crc16frc_pkg::ST_GOOD)
            |-> frame_length_reg >= 16'(crc16frc_pkg::FRAME_MIN),
        "good frame shorter than header plus CRC")
    `CRC16FRC_NEVER(a_stall_needs_byte,
        in_stall && !s1_valid_reg,
        "input stalled with empty input register")

endmodule

`default_nettype wire

@@ sim/crc16_frame_receive_checker_monitor.sv @@
`timescale 1ns / 1ps
// Watches the byte, result and max_length channels of the CRC-16 frame receive
// checker, predicts each status beat and compares it. Uses crc16frc_pkg.

module crc16_frame_receive_checker_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [15:0] frame_length,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] max_length,
    output int          pending,
    output int          errors
);

    typedef struct packed {
        crc16frc_pkg::status_t st;
        logic [15:0]           flen;
    } frame_verdict_t;

    frame_verdict_t verdicts_due[$];
    frame_verdict_t due;
    frame_verdict_t want;

    logic [15:0] buf_limit;
    logic [15:0] rx_count;
    logic [15:0] rx_plen;
    logic [15:0] rx_crc;
    logic [7:0]  rx_crc_lo;
    int          beat_no;

    function automatic logic [15:0] crc_acc(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        return c;
    endfunction

    function automatic void restart_frame();
        rx_count  = '0;
        rx_plen   = '0;
        rx_crc    = '0;
        rx_crc_lo = '0;
    endfunction

    // advance the frame state by one received byte, return its status beat
    function automatic frame_verdict_t frame_step(input logic [7:0] b);
        frame_verdict_t v;
        logic [16:0]    crc_end;
        logic [16:0]    next_cnt;
        crc_end = {1'b0, rx_plen} + 17'(crc16frc_pkg::HEADER_BYTES);
        v.st    = crc16frc_pkg::ST_CONTINUE;
        v.flen  = '0;
        if (rx_count < crc16frc_pkg::HEADER_BYTES)
        begin
            rx_crc = crc_acc(rx_crc, b);
            if (rx_count == crc16frc_pkg::LEN_LO_POS)
                rx_plen[7:0] = b;
            else if (rx_count == crc16frc_pkg::LEN_HI_POS)
                rx_plen[15:8] = b;
        end
        else if ({1'b0, rx_count} < crc_end)
            rx_crc = crc_acc(rx_crc, b);
        else if ({1'b0, rx_count} == crc_end)
            rx_crc_lo = b;
        else if ({b, rx_crc_lo} == rx_crc)
        begin
            v.st   = crc16frc_pkg::ST_GOOD;
            v.flen = rx_count + 16'd1;
        end
        else
            v.st = crc16frc_pkg::ST_CRC_ERR;

        if (v.st == crc16frc_pkg::ST_CONTINUE)
        begin
            next_cnt = {1'b0, rx_count} + 17'd1;
            if (next_cnt >= {1'b0, buf_limit})
            begin
                v.st = crc16frc_pkg::ST_FULL;
                restart_frame();
            end
            else
                rx_count = next_cnt[15:0];
        end
        else
            restart_frame();
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < 50)
            $display("%0t: result beat %0d: %s", $realtime, beat_no, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_limit = crc16frc_pkg::MAX_LENGTH_RST;
            restart_frame();
            verdicts_due.delete();
            pending = 0;
            errors  = 0;
            beat_no = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                    report_mismatch($sformatf("unexpected beat, status %0d length %0d",
                                              status, frame_length));
                else
                begin
                    due = verdicts_due.pop_front();
                    if (status !== due.st)
                        report_mismatch($sformatf("status %0d, want %0d", status, due.st));
                    if (frame_length !== due.flen)
                        report_mismatch($sformatf("frame_length %0d, want %0d",
                                                  frame_length, due.flen));
                end
                beat_no++;
            end
            if (cfg_valid && cfg_ready)
                buf_limit = max_length;
            if (in_valid && !in_stall)
            begin
                want = frame_step(data_byte);
                verdicts_due.push_back(want);
            end
            pending = verdicts_due.size();
        end
    end

endmodule

@@ sim/crc16_frame_receive_checker_test.sv @@
`timescale 1ns / 1ps
// Top of the CRC-16 frame receive checker testbench: clock, reset, byte and
// max_length stimulus, verdict. Needs crc16frc_pkg, the block and the monitor.

module crc16_frame_receive_checker_test;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte    = 8'h00;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [1:0]  status;
    logic [15:0] frame_length;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [15:0] max_length   = 16'd1024;

    int pending;
    int errors;
    int tx_idle_pct  = 33;
    int rx_stall_pct = 65;
    int bytes_sent   = 0;
    int frames_sent  = 0;
    int limits_used  = 0;

    crc16_frame_receive_checker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .frame_length (frame_length),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .max_length   (max_length)
    );

    crc16_frame_receive_checker_monitor u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .frame_length (frame_length),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .max_length   (max_length),
        .pending      (pending),
        .errors       (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < rx_stall_pct);

    initial
    begin
        #5000000;
        $display("timeout with %0d results outstanding", pending);
        $display("crc16_frame_receive_checker_test: FAIL");
        $finish;
    end

    function automatic logic [15:0] crc16_upd(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
        end
        return c;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(input logic [15:0] v);
        drain();
        cfg_valid  <= 1'b1;
        max_length <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        limits_used++;
    endtask

    // mostly well-formed frames; noisy phases add truncated bursts and
    // headers that declare a payload far past the buffer
    task automatic send_frame(input bit noisy, input bit roomy);
        logic [7:0]  fr[$];
        logic [15:0] plen;
        logic [15:0] crc;
        int          kind;
        int          pick;
        int          idx;
        kind = $urandom_range(99);
        pick = $urandom_range(99);
        if (pick < 80)
            plen = 16'($urandom_range(12));
        else if (pick < 95 || !roomy)
            plen = 16'($urandom_range(60, 13));
        else
            plen = 16'($urandom_range(300, 61));

        if (noisy && kind >= 90)
            repeat ($urandom_range(20, 1))
                fr.push_back(8'($urandom_range(255)));
        else
        begin
            if (noisy && kind >= 80)
                plen = 16'($urandom_range(65535, 100));
            repeat (crc16frc_pkg::HEADER_BYTES)
                fr.push_back(8'($urandom_range(255)));
            fr[crc16frc_pkg::LEN_LO_POS] = plen[7:0];
            fr[crc16frc_pkg::LEN_HI_POS] = plen[15:8];
            if (noisy && kind >= 80)
                repeat ($urandom_range(8))
                    fr.push_back(8'($urandom_range(255)));
            else
            begin
                repeat (plen)
                    fr.push_back(8'($urandom_range(255)));
                crc = '0;
                foreach (fr[i])
                    crc = crc16_upd(crc, fr[i]);
                fr.push_back(crc[7:0]);
                fr.push_back(crc[15:8]);
                if (kind >= 65 && kind < 80)
                begin
                    idx = $urandom_range(fr.size() - 1);
                    if (idx == crc16frc_pkg::LEN_LO_POS || idx == crc16frc_pkg::LEN_HI_POS)
                        idx = fr.size() - 1;
                    fr[idx] = fr[idx] ^ 8'(1 << $urandom_range(7));
                end
            end
        end
        foreach (fr[i])
            push_byte(fr[i]);
        frames_sent++;
    endtask

    task automatic run_phase(input logic [15:0] lim, input bit noisy, input int budget);
        int start;
        set_limit(lim);
        start = bytes_sent;
        while (bytes_sent - start < budget)
            send_frame(noisy, lim >= 16'd1024);
    endtask

    initial
    begin
        logic [15:0] crc;
        logic [7:0]  b;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit: minimal good frame, header of 00/ff beats, zero length
        crc = '0;
        for (int i = 0; i < crc16frc_pkg::HEADER_BYTES; i++)
        begin
            b   = (i < crc16frc_pkg::LEN_LO_POS && i % 2 == 1) ? 8'hff : 8'h00;
            crc = crc16_upd(crc, b);
            push_byte(b);
        end
        push_byte(crc[7:0]);
        push_byte(crc[15:8]);

        // zero limit: every beat is buffer full
        set_limit(16'd0);
        push_byte(8'h00);
        push_byte(8'hff);
        push_byte(8'ha5);

        run_phase(16'd1024, 1'b0, 170);
        run_phase(16'd18, 1'b1, 120);

        tx_idle_pct  = 65;
        rx_stall_pct = 33;
        run_phase(16'hffff, 1'b0, 170);
        run_phase(16'($urandom_range(120, 19)), 1'b1, 140);

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        run_phase(16'd17, 1'b1, 40);
        run_phase(16'd1024, 1'b0, 200);

        drain();
        repeat (6)
            @(posedge clk);

        $display("%0d bytes in %0d frames sent, max_length written %0d times (0 to 65535),",
                 bytes_sent, frames_sent, limits_used);
        $display("good, corrupted, truncated and oversized frames under three idle mixes");
        if (errors == 0)
            $display("crc16_frame_receive_checker_test: PASS");
        else
            $display("crc16_frame_receive_checker_test: FAIL");
        $finish;
    end

endmodule
